/* rtl/grol_pkg.sv */
`timescale 1ns / 1ps
package grol_pkg;
   localparam int DEPTH = 32;
   localparam int IDX_BITS = 5;
   localparam int CNT_BITS = 6;
   localparam int ID_BITS = 32;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_TO_TOP = 3'd2, CMD_TO_BOTTOM = 3'd3,
      CMD_BEST = 3'd4, CMD_WALK = 3'd5, CMD_SET_ATTR = 3'd6, CMD_NONE = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0, ST_NOOP = 2'd1, ST_FULL = 2'd2, ST_UNUSED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] entry_id;
      logic [3:0]  group;
      logic        eligible;
   } req_type;

   typedef struct packed {
      logic [31:0] found_id;
      logic        found;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [3:0]         group;
      logic               eligible;
   } entry_type;

   typedef enum logic [2:0] {
      FSM_IDLE, FSM_SCAN, FSM_DECIDE, FSM_MOVE, FSM_WALK, FSM_OUT
   } fsm_type;

   // Memory port bundle from the sequencer to the entry store.
   typedef struct packed {
      logic                re;
      logic [IDX_BITS-1:0] raddr;
      logic                we;
      logic [IDX_BITS-1:0] waddr;
      entry_type           wdata;
   } mem_ctl_type;
endpackage

/* rtl/grol_store.sv */
`timescale 1ns / 1ps
module grol_store
   import grol_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type ctl,
   output entry_type   rdata
);
   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata <= mem[ctl.raddr];
      end
   end
endmodule

/* rtl/grol_seq.sv */
`timescale 1ns / 1ps
module grol_seq
   import grol_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   output mem_ctl_type ctl,
   input  entry_type   rdata
);
   fsm_type state_ff, state_in;
   req_type cmd_ff, cmd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   // scan pointer: address whose data arrives next cycle
   logic [CNT_BITS-1:0] ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [IDX_BITS-1:0] rpos_ff, rpos_in;
   logic                hit_ff, hit_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   entry_type           own_ff, own_in;
   logic                gl_ff, gl_in;
   logic [IDX_BITS-1:0] glast_ff, glast_in;
   logic                best_ff, best_in;
   logic [ID_BITS-1:0]  bid_ff, bid_in;
   // move: source/destination range and shift direction
   logic [CNT_BITS-1:0] mcur_ff, mcur_in, mend_ff, mend_in;
   logic                mup_ff, mup_in;
   logic [IDX_BITS-1:0] dest_ff, dest_in;
   entry_type           ins_ff, ins_in;
   logic                wprev_ff, wprev_in;
   logic [ID_BITS-1:0]  wid_ff, wid_in;
   logic                rv_ff, rv_in;
   rsp_type             rd_ff, rd_in;

   // decision
   logic        mov_go, mdone, walk_end;
   status_type  dstat;
   logic [CNT_BITS-1:0] d_cur, d_end, d_cnt;
   logic        d_up;
   logic [IDX_BITS-1:0] d_dest;
   entry_type   d_ins;
   logic        d_setattr;
   logic [IDX_BITS-1:0] lp;
   logic        full;

   logic mvalid_ff, mvalid_in;
   logic [IDX_BITS-1:0] mwa_ff, mwa_in;
   logic more;
   logic fin_pend_ff, fin_pend_in;

   logic [CNT_BITS-1:0] wptr_ff, wptr_in;
   logic                wpend_ff, wpend_in;

   logic rsp_free;
   assign rsp_free = !rv_ff || !rsp_stall;
   assign rsp_valid = rv_ff;
   assign rsp_data = rd_ff;
   assign req_stall = (state_ff != FSM_IDLE);

   logic [3:0] g;
   assign g = cmd_ff.group;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:   if (req_valid) state_in = FSM_SCAN;
         FSM_SCAN:   if (!pend_ff && ptr_ff >= count_ff) state_in =
                        (cmd_ff.command == CMD_WALK) ? FSM_WALK : FSM_DECIDE;
         FSM_DECIDE: if (rsp_free) state_in = mov_go ? FSM_MOVE : FSM_OUT;
         FSM_MOVE:   if (mdone) state_in = FSM_OUT;
         FSM_WALK:   if (walk_end) state_in = FSM_OUT;
         FSM_OUT:    if (rsp_free) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   assign full = (count_ff == CNT_BITS'(DEPTH));

   always_comb begin
      mov_go = 1'b0; dstat = ST_NOOP; d_up = 1'b0;
      d_cur = '0; d_end = '0; d_dest = '0; d_cnt = count_ff; d_setattr = 1'b0;
      d_ins.id = cmd_ff.entry_id; d_ins.group = cmd_ff.group;
      d_ins.eligible = cmd_ff.eligible;
      lp = glast_ff;
      case (cmd_ff.command)
         CMD_ADD: if (!hit_ff) begin
            if (full) dstat = ST_FULL;
            else begin
               dstat = ST_DONE; mov_go = 1'b1; d_dest = count_ff[IDX_BITS-1:0];
               d_cur = count_ff; d_end = count_ff; d_cnt = count_ff + 1'b1;
            end
         end
         CMD_REMOVE: if (hit_ff) begin
            // shift down: dest i <- i+1 for i in [pos, count-2]
            dstat = ST_DONE; mov_go = 1'b1; d_up = 1'b1;
            d_cur = {1'b0, pos_ff}; d_end = count_ff - 1'b1; d_cnt = count_ff - 1'b1;
            d_dest = IDX_BITS'(count_ff); // no final write target inside range
         end
         CMD_TO_TOP: begin
            if (hit_ff) begin
               if (pos_ff != '0) begin
                  dstat = ST_DONE; mov_go = 1'b1;
                  d_ins = own_ff; d_cur = {1'b0, pos_ff}; d_end = {1'b0, pos_ff};
                  d_dest = '0;
               end
            end else if (full) dstat = ST_FULL;
            else begin
               dstat = ST_DONE; mov_go = 1'b1; d_dest = '0;
               d_cur = count_ff; d_end = count_ff; d_cnt = count_ff + 1'b1;
            end
         end
         CMD_TO_BOTTOM: if (gl_ff) begin
            if (hit_ff) begin
               dstat = ST_DONE; mov_go = 1'b1; d_ins = own_ff;
               if (pos_ff < glast_ff) begin
                  d_up = 1'b1; d_cur = {1'b0, pos_ff}; d_end = {1'b0, glast_ff};
                  d_dest = glast_ff;
               end else begin
                  d_cur = {1'b0, pos_ff}; d_end = {1'b0, pos_ff};
                  d_dest = glast_ff + 1'b1;
               end
            end else if (full) dstat = ST_FULL;
            else begin
               dstat = ST_DONE; mov_go = 1'b1; d_dest = lp + 1'b1;
               d_cur = count_ff; d_end = count_ff; d_cnt = count_ff + 1'b1;
            end
         end
         CMD_BEST: dstat = best_ff ? ST_DONE : ST_NOOP;
         CMD_SET_ATTR: if (hit_ff) begin
            dstat = ST_DONE; d_setattr = 1'b1;
         end
         default: dstat = ST_NOOP;
      endcase
   end

   // Move engine: one read per cycle, write the previous read one slot away.
   // Down (insert): walk mcur from src down to dest+1: mem[mcur] <= mem[mcur-1].
   // Up (delete, move to bottom): walk mcur from src up to end-1: mem[mcur] <= mem[mcur+1].
   assign more = mup_ff ? (mcur_ff < mend_ff) : (mcur_ff > {1'b0, dest_ff});
   assign mdone = !more && !mvalid_ff && !fin_pend_ff;

   // Walk: read every entry again, emitting group members with one behind.
   assign walk_end = !wpend_ff && wptr_ff >= count_ff && !rv_ff;

   always_comb begin
      cmd_in = cmd_ff; count_in = count_ff; ptr_in = ptr_ff; pend_in = 1'b0;
      rpos_in = rpos_ff; hit_in = hit_ff; pos_in = pos_ff; own_in = own_ff;
      gl_in = gl_ff; glast_in = glast_ff; best_in = best_ff; bid_in = bid_ff;
      mcur_in = mcur_ff; mend_in = mend_ff; mup_in = mup_ff; dest_in = dest_ff;
      ins_in = ins_ff; wprev_in = wprev_ff; wid_in = wid_ff;
      mvalid_in = 1'b0; mwa_in = mwa_ff; fin_pend_in = fin_pend_ff;
      wptr_in = wptr_ff; wpend_in = 1'b0;
      rv_in = rv_ff && rsp_stall; rd_in = rd_ff;
      ctl = '0;
      case (state_ff)
         FSM_IDLE: if (req_valid) begin
            cmd_in = req_data; ptr_in = '0; hit_in = 1'b0; gl_in = 1'b0;
            best_in = 1'b0; pos_in = '0;
         end
         FSM_SCAN: begin
            if (pend_ff) begin
               if (rdata.id == cmd_ff.entry_id && !hit_in) begin
                  hit_in = 1'b1; pos_in = rpos_ff; own_in = rdata;
               end else if (rdata.group == g) begin
                  gl_in = 1'b1; glast_in = rpos_ff;
               end
               if (rdata.group == g && rdata.eligible && !best_ff) begin
                  best_in = 1'b1; bid_in = rdata.id;
               end
            end
            if (ptr_ff < count_ff) begin
               ctl.re = 1'b1; ctl.raddr = ptr_ff[IDX_BITS-1:0];
               rpos_in = ptr_ff[IDX_BITS-1:0]; pend_in = 1'b1; ptr_in = ptr_ff + 1'b1;
            end
            wptr_in = '0; wprev_in = 1'b0;
         end
         FSM_DECIDE: begin
            // The previous command's result may still be waiting in the
            // result register; the decision holds until it has gone.
            if (rsp_free) begin
               mcur_in = d_cur; mend_in = d_end; mup_in = d_up; dest_in = d_dest;
               ins_in = d_ins; count_in = d_cnt; fin_pend_in = mov_go;
               if (d_setattr) begin
                  ctl.we = 1'b1; ctl.waddr = pos_ff;
                  ctl.wdata = own_ff; ctl.wdata.group = g;
                  ctl.wdata.eligible = cmd_ff.eligible;
               end
               rd_in = '0; rd_in.status = dstat; rd_in.last = 1'b1;
               if (cmd_ff.command == CMD_BEST && best_ff) begin
                  rd_in.found = 1'b1; rd_in.found_id = bid_ff;
               end
            end
         end
         FSM_MOVE: begin
            if (mvalid_ff) begin
               ctl.we = 1'b1; ctl.waddr = mwa_ff; ctl.wdata = rdata;
            end
            if (more) begin
               ctl.re = 1'b1;
               if (mup_ff) begin
                  ctl.raddr = IDX_BITS'(mcur_ff + 1'b1); mwa_in = mcur_ff[IDX_BITS-1:0];
                  mcur_in = mcur_ff + 1'b1;
               end else begin
                  ctl.raddr = IDX_BITS'(mcur_ff - 1'b1); mwa_in = mcur_ff[IDX_BITS-1:0];
                  mcur_in = mcur_ff - 1'b1;
               end
               mvalid_in = 1'b1;
            end else if (!mvalid_ff && fin_pend_ff) begin
               fin_pend_in = 1'b0;
               if (!(cmd_ff.command == CMD_REMOVE)) begin
                  ctl.we = 1'b1; ctl.waddr = dest_ff; ctl.wdata = ins_ff;
               end
            end
         end
         FSM_WALK: begin
            if (wpend_ff && rdata.group == g) begin
               wprev_in = 1'b1; wid_in = rdata.id;
            end
            if (!rv_in) begin
               if (wpend_ff && rdata.group == g && wprev_ff) begin
                  rv_in = 1'b1; rd_in = '0; rd_in.found = 1'b1; rd_in.found_id = wid_ff;
                  rd_in.status = ST_DONE;
               end
               if (!(wpend_ff && rdata.group == g && wprev_ff) && wptr_ff < count_ff) begin
                  ctl.re = 1'b1; ctl.raddr = wptr_ff[IDX_BITS-1:0];
                  wpend_in = 1'b1; wptr_in = wptr_ff + 1'b1;
               end
            end else begin
               // hold a pending read result by re-reading the same address
               if (wpend_ff) begin
                  ctl.re = 1'b1; ctl.raddr = IDX_BITS'(wptr_ff - 1'b1); wpend_in = 1'b1;
                  wprev_in = wprev_ff; wid_in = wid_ff;
               end
            end
            if (walk_end) begin
               rd_in = '0; rd_in.last = 1'b1;
               if (wprev_ff) begin
                  rd_in.found = 1'b1; rd_in.found_id = wid_ff; rd_in.status = ST_DONE;
               end else rd_in.status = ST_NOOP;
            end
         end
         FSM_OUT: if (rsp_free) rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE; count_ff <= '0; rv_ff <= 1'b0; pend_ff <= 1'b0;
         mvalid_ff <= 1'b0; wpend_ff <= 1'b0; fin_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in; pend_ff <= pend_in;
         mvalid_ff <= mvalid_in; wpend_ff <= wpend_in; fin_pend_ff <= fin_pend_in;
      end
      cmd_ff <= cmd_in; ptr_ff <= ptr_in; rpos_ff <= rpos_in; hit_ff <= hit_in;
      pos_ff <= pos_in; own_ff <= own_in; gl_ff <= gl_in; glast_ff <= glast_in;
      best_ff <= best_in; bid_ff <= bid_in; mcur_ff <= mcur_in; mend_ff <= mend_in;
      mup_ff <= mup_in; dest_ff <= dest_in; ins_ff <= ins_in;
      wprev_ff <= wprev_in; wid_ff <= wid_in; mwa_ff <= mwa_in; wptr_ff <= wptr_in;
      rd_ff <= rd_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH)) else $error("entry count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != FSM_IDLE |-> req_stall) else $error("accept while busy");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rd_ff))
      else $error("stalled result changed");
endmodule

/* rtl/grouped_recency_order_list_unit.sv */
`timescale 1ns / 1ps
// Grouped most-recent-first list of up to 32 ids kept in one synchronous memory.
// A command scans the list, one entry a cycle, then may shift entries one a cycle.
// Throughput: one command at a time; walk emits one transfer per group member.
// A result still waiting on the output holds the next command at its decision.
// Reset (synchronous, active high) empties the list; the memory is not cleared.
module grouped_recency_order_list_unit
   import grol_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   mem_ctl_type ctl;
   entry_type   rdata;

   // The sequencer owns the list order; the store holds the entries.
   grol_seq u_seq (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .ctl, .rdata
   );
   grol_store u_store (.clock, .ctl, .rdata);
endmodule
